// ===== rtl/core/tlb_hit_with_selectable_replacement_macros.svh =====
// Assertion macros for the TLB block and its checker.
`ifndef TLB_HIT_WITH_SELECTABLE_REPLACEMENT_MACROS_SVH
`define TLB_HIT_WITH_SELECTABLE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TLBSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TLBSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tlbsr_pkg.sv =====
// Shared types and constants of the TLB with selectable replacement.
package tlbsr_pkg;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_LIFO = 2'd1,
    POL_LRU  = 2'd2
  } policy_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int POLICY_W   = 2;
  localparam int SHIFT_W    = 5;
  localparam int CAP_W      = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 2'd2;

  localparam logic [POLICY_W-1:0] POLICY_RST = 2'd0;
  localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 5'd12;
  localparam logic [CAP_W-1:0]    CAP_RST    = 5'd16;

endpackage

// ===== rtl/core/tlbsr_req_if.sv =====
// Request channel: one virtual address per word.
interface tlbsr_req_if #(
  parameter int ADDR_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] access_address;

  modport source (output valid, output access_address, input ready);
  modport sink   (input valid, input access_address, output ready);
endinterface

// ===== rtl/core/tlbsr_rsp_if.sv =====
// Response channel: hit or miss per word.
interface tlbsr_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink   (input valid, input hit, output ready);
endinterface

// ===== rtl/core/tlb_hit_with_selectable_replacement.sv =====
// A request word is held in the request register, its result in the response register.
// Throughput: one word per cycle unless the receiver stalls; the whole lookup and update
// of all entries is done between the request register and the response register.
// Reset (rst_n low, synchronous): all entries invalid, fill count zero, policy FIFO,
// page shift 12, capacity 16; no response pending.
module tlb_hit_with_selectable_replacement
  import tlbsr_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int ADDR_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tlbsr_req_if.sink             in_ch,
  tlbsr_rsp_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
  localparam logic [CMP_W-1:0] MAX_CAP = CMP_W'(MAX_ENTRIES);

  // configuration
  logic [POLICY_W-1:0] cfg_policy_r;
  logic [SHIFT_W-1:0]  cfg_shift_r;
  logic [CAP_W-1:0]    cfg_cap_r;

  // pipeline
  logic                 s1_valid_r, s1_valid_nxt;
  logic [ADDR_BITS-1:0] s1_addr_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r;

  // entry store
  logic [ADDR_BITS-1:0] page_r [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [RANK_W-1:0]    rank_r [MAX_ENTRIES];
  logic [RANK_W-1:0]    rank_nxt [MAX_ENTRIES];
  logic [FILL_W-1:0]    fill_r, fill_nxt;

  logic                 out_free, fire, in_acc;
  policy_t              mode;
  logic [ADDR_BITS-1:0] page;
  logic [CMP_W-1:0]     cap;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic [RANK_W-1:0]    hit_rank;
  logic                 need_evict, victim_found, do_evict;
  logic [RANK_W-1:0]    want, evict_rank;
  logic [FILL_W-1:0]    fill_m1;
  logic [IDX_W-1:0]     victim_idx;
  logic [MAX_ENTRIES-1:0] valid_ae;
  logic [RANK_W-1:0]    rank_ae [MAX_ENTRIES];
  logic                 slot_found;
  logic [IDX_W-1:0]     slot_idx;

  assign out_free      = !out_valid_r || out_ch.ready;
  assign fire          = s1_valid_r && out_free;
  assign in_ch.ready   = !s1_valid_r || fire;
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.hit    = out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_policy_r <= POLICY_RST;
      cfg_shift_r  <= SHIFT_RST;
      cfg_cap_r    <= CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY: cfg_policy_r <= cfg_wdata[POLICY_W-1:0];
        CFG_SHIFT:  cfg_shift_r  <= cfg_wdata[SHIFT_W-1:0];
        CFG_CAP:    cfg_cap_r    <= cfg_wdata[CAP_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_policy_r)
      POL_LIFO: mode = POL_LIFO;
      POL_LRU:  mode = POL_LRU;
      default:  mode = POL_FIFO;  // unused code runs as FIFO
    endcase
  end

  always_comb begin
    page = s1_addr_r >> cfg_shift_r;
    cap  = CMP_W'(cfg_cap_r);
    if (cap == '0) cap = CMP_W'(1);
    if (cap > MAX_CAP) cap = MAX_CAP;
  end

  // CAM lookup, lowest matching entry wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && page_r[i] == page) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
    hit_rank = rank_r[hit_idx];
  end

  // victim: rank 0 is the newest, fill-1 the oldest
  always_comb begin
    fill_m1      = fill_r - FILL_W'(1);
    need_evict   = (CMP_W'(fill_r) >= cap) && (fill_r != '0);
    want         = (mode == POL_LIFO) ? '0 : fill_m1[RANK_W-1:0];
    victim_found = 1'b0;
    victim_idx   = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && rank_r[i] == want) begin
        victim_found = 1'b1;
        victim_idx   = IDX_W'(i);
      end
    end
    do_evict   = need_evict && victim_found;
    evict_rank = rank_r[victim_idx];
  end

  // state after eviction, then first free slot
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      valid_ae[i] = valid_r[i] && !(do_evict && victim_idx == IDX_W'(i));
      if (do_evict && valid_r[i] && rank_r[i] > evict_rank)
        rank_ae[i] = rank_r[i] - RANK_W'(1);
      else
        rank_ae[i] = rank_r[i];
    end
    slot_found = 1'b0;
    slot_idx   = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_ae[i]) begin
        slot_found = 1'b1;
        slot_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    fill_nxt  = fill_r;
    for (int i = 0; i < MAX_ENTRIES; i++) rank_nxt[i] = rank_r[i];
    if (fire) begin
      if (hit) begin
        if (mode == POL_LRU) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (hit_idx == IDX_W'(i))
              rank_nxt[i] = '0;
            else if (valid_r[i] && rank_r[i] < hit_rank)
              rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
      end else begin
        valid_nxt = valid_ae;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_found && slot_idx == IDX_W'(i))
            rank_nxt[i] = '0;
          else if (slot_found && valid_ae[i])
            rank_nxt[i] = rank_ae[i] + RANK_W'(1);
          else
            rank_nxt[i] = rank_ae[i];
        end
        if (slot_found) valid_nxt[slot_idx] = 1'b1;
        fill_nxt = fill_r - FILL_W'(do_evict) + FILL_W'(slot_found);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)    s1_valid_nxt = 1'b1;
    else if (fire) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (fire)              out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      fill_r      <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) rank_r[i] <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      fill_r      <= fill_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) rank_r[i] <= rank_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_addr_r <= in_ch.access_address;
    if (fire)   out_hit_r <= hit;
    if (fire && !hit && slot_found) page_r[slot_idx] <= page;
  end

endmodule

// ===== rtl/core/tlbsr_checker.sv =====
// Port-level checker for the TLB block, with its bind.
`include "tlb_hit_with_selectable_replacement_macros.svh"

module tlbsr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  // an empty response register never holds back the request side
  `TLBSR_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready, "request stalled with response slot empty")
  // a fresh response needs a word taken into the request register before it
  `TLBSR_ASSERT_IMP(a_resp_has_word, out_valid && !$past(out_valid), $past(in_valid && in_ready, 2), "response without a request word")
  `TLBSR_ASSERT_NXT(a_hold_valid, out_valid && !out_ready, out_valid, "response dropped while stalled")
  `TLBSR_ASSERT_NXT(a_hold_hit, out_valid && !out_ready, $stable(out_hit), "hit changed while stalled")

endmodule

bind tlb_hit_with_selectable_replacement tlbsr_checker u_tlbsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit)
);

// ===== test/tlbsr_hit_checker.sv =====
// Scoreboard for the TLB: tracks the page store and checks each response word.
module tlbsr_hit_checker
  import tlbsr_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tlbsr_req_if                  req_mon,
  tlbsr_rsp_if                  rsp_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    words_checked,
  output int                    hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]         tag_q  [MAX_ENTRIES];
  bit                  live_q [MAX_ENTRIES];
  int unsigned         age_q  [MAX_ENTRIES];
  int unsigned         fill;
  logic [POLICY_W-1:0] policy_r;
  logic [SHIFT_W-1:0]  shift_r;
  logic [CAP_W-1:0]    cap_r;
  bit                  expected_hits [$];

  // Looks the address up in the modelled store and applies the replacement update.
  // Age 0 is the newest insertion (FIFO/LIFO) or the most recent use (LRU).
  function automatic bit lookup_page(input logic [31:0] addr);
    logic [31:0] vpn;
    policy_t     mode;
    int unsigned limit;
    int unsigned want_age;
    int unsigned r;
    int          hit_at;
    int          victim;
    int          slot;
    vpn    = addr >> shift_r;
    mode   = (policy_r == POL_LIFO) ? POL_LIFO : (policy_r == POL_LRU) ? POL_LRU : POL_FIFO;
    limit  = (cap_r == 0) ? 1 : (cap_r > MAX_ENTRIES) ? MAX_ENTRIES : cap_r;
    hit_at = -1;
    victim = -1;
    slot   = -1;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (hit_at < 0 && live_q[i] && tag_q[i] == vpn) hit_at = i;

    if (hit_at >= 0) begin
      if (mode == POL_LRU) begin
        r = age_q[hit_at];
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (live_q[i] && age_q[i] < r) age_q[i]++;
        age_q[hit_at] = 0;
      end
      return 1'b1;
    end

    // full (or capacity lowered under the fill): drop exactly one victim
    if (fill >= limit && fill > 0) begin
      want_age = (mode == POL_LIFO) ? 0 : fill - 1;
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (victim < 0 && live_q[i] && age_q[i] == want_age) victim = i;
      if (victim >= 0) begin
        r = age_q[victim];
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (live_q[i] && age_q[i] > r) age_q[i]--;
        live_q[victim] = 1'b0;
        age_q[victim]  = 0;
        fill--;
      end
    end

    for (int i = 0; i < MAX_ENTRIES; i++)
      if (slot < 0 && !live_q[i]) slot = i;
    if (slot >= 0) begin
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (live_q[i]) age_q[i]++;
      tag_q[slot]  = vpn;
      live_q[slot] = 1'b1;
      age_q[slot]  = 0;
      fill++;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    bit want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        live_q[i] = 1'b0;
        age_q[i]  = 0;
      end
      fill          = 0;
      policy_r      = POLICY_RST;
      shift_r       = SHIFT_RST;
      cap_r         = CAP_RST;
      expected_hits.delete();
      fail_count    = 0;
      pending       = 0;
      words_checked = 0;
      hits_seen     = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLICY: policy_r = cfg_wdata[POLICY_W-1:0];
          CFG_SHIFT:  shift_r  = cfg_wdata[SHIFT_W-1:0];
          CFG_CAP:    cap_r    = cfg_wdata[CAP_W-1:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        expected_hits.push_back(lookup_page(req_mon.access_address));
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_hits.size() == 0) begin
          fail_count++;
          $display("%0t: response word with none expected, expected none got hit=%0b",
                   $time, rsp_mon.hit);
        end else begin
          want = expected_hits.pop_front();
          words_checked++;
          if (rsp_mon.hit === 1'b1) hits_seen++;
          if (rsp_mon.hit !== want) begin
            fail_count++;
            $display("%0t: hit mismatch, expected %0b got %0b", $time, want, rsp_mon.hit);
          end
        end
      end
      pending = expected_hits.size();
    end
  end

endmodule

// ===== test/tb_tlb_hit_with_selectable_replacement.sv =====
// Top of the TLB testbench: clock, reset, stimulus phases and the verdict.
module tb_tlb_hit_with_selectable_replacement;
  import tlbsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                    CYCLE_LIMIT    = 200000;
  localparam int                    RAND_PHASES    = 10;
  localparam int                    WORDS_PER_PHASE = 123;
  // policy code with no meaning of its own; the block treats it as FIFO
  localparam logic [CFG_DATA_W-1:0] POL_CODE_SPARE = 5'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    words_checked;
  int                    hits_seen;
  int                    send_gap_pct;
  int                    stall_pct;
  int                    cycle_count;

  tlbsr_req_if #(.ADDR_BITS(32)) req_ch ();
  tlbsr_rsp_if                   rsp_ch ();

  tlb_hit_with_selectable_replacement #(
    .MAX_ENTRIES(16),
    .ADDR_BITS  (32)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (req_ch),
    .out_ch   (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  tlbsr_hit_checker #(.MAX_ENTRIES(16)) u_hit_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .words_checked(words_checked),
    .hits_seen    (hits_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count, pending);
      $display("tlb_hit_with_selectable_replacement regression: fail");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    rsp_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [31:0] addr);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.access_address <= addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_responses();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Only called with the block drained.
  task automatic set_tlb(input logic [CFG_DATA_W-1:0] pol, input logic [CFG_DATA_W-1:0] shift,
                         input logic [CFG_DATA_W-1:0] cap);
    write_reg(CFG_POLICY, pol);
    write_reg(CFG_SHIFT, shift);
    write_reg(CFG_CAP, cap);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0]           base_pool [24];
    logic [31:0]           hi_mask;
    logic [31:0]           addr;
    logic [CFG_DATA_W-1:0] pol;
    logic [CFG_DATA_W-1:0] shift;
    logic [CFG_DATA_W-1:0] cap;
    int                    pool_size;
    cycle_count           = 0;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_POLICY;
    cfg_wdata             = '0;
    req_ch.valid          = 1'b0;
    req_ch.access_address = '0;
    rsp_ch.ready          = 1'b0;
    send_gap_pct          = 0;
    stall_pct             = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings, extremes of the address
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0FFF);
    send_word(32'hFFFF_F000);
    wait_for_responses();

    // spare policy code acts as FIFO, capacity zero acts as one
    set_tlb(POL_CODE_SPARE, 5'd0, 5'd0);
    send_word(32'h0000_0001);
    send_word(32'h0000_0001);
    send_word(32'h0000_0002);
    send_word(32'h0000_0001);
    wait_for_responses();

    // widest page: only two page numbers exist
    set_tlb({3'b000, POL_LIFO}, 5'd31, 5'd2);
    send_word(32'h0000_0000);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    wait_for_responses();

    // capacity above the store size is clamped
    set_tlb({3'b000, POL_LRU}, 5'd4, 5'd31);
    send_word(32'h0000_0010);
    send_word(32'h0000_0020);
    send_word(32'h0000_0030);
    send_word(32'h0000_001F);
    wait_for_responses();

    // capacity lowered under the fill: one victim per miss, fill held
    set_tlb({3'b000, POL_LRU}, 5'd4, 5'd2);
    send_word(32'h0000_0040);
    send_word(32'h0000_0020);
    send_word(32'h0000_0010);
    wait_for_responses();

    // policy switched with the store populated: ages reread as LIFO
    set_tlb({3'b000, POL_LIFO}, 5'd4, 5'd2);
    send_word(32'h0000_0050);
    send_word(32'h0000_0010);
    wait_for_responses();

    // Random phases: hot sets of 2 to 24 page bases, some stray words
    for (int p = 0; p < RAND_PHASES; p++) begin
      pol   = CFG_DATA_W'(p % 4);
      shift = (p == 1) ? 5'd0 : (p == 2) ? 5'd31 : (p == 7) ? 5'd12
                                : CFG_DATA_W'($urandom_range(31));
      cap   = (p == 3) ? 5'd1 : (p == 4) ? 5'd16 : (p == 5) ? 5'd0 : (p == 6) ? 5'd31
                                : CFG_DATA_W'($urandom_range(1, 16));
      set_tlb(pol, shift, cap);
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 64; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 64; end
        default: begin send_gap_pct = 35; stall_pct = 35; end
      endcase
      hi_mask   = 32'hFFFF_FFFF << shift;
      pool_size = $urandom_range(2, 24);
      for (int k = 0; k < 24; k++) base_pool[k] = $urandom();
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if ($urandom_range(15) == 0) base_pool[$urandom_range(pool_size - 1)] = $urandom();
        if ($urandom_range(9) == 0)
          addr = $urandom();
        else
          addr = (base_pool[$urandom_range(pool_size - 1)] & hi_mask) | ($urandom() & ~hi_mask);
        send_word(addr);
      end
      wait_for_responses();
      send_gap_pct = 0;
      stall_pct    = 0;
    end

    repeat (4) @(negedge clk);
    $display("checked %0d response words (%0d hits) over FIFO, LIFO, LRU and the spare code,",
             words_checked, hits_seen);
    $display("page shifts 0 to 31, capacities 0 to 31, with sender gaps and receiver stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("tlb_hit_with_selectable_replacement regression: pass");
    end else begin
      $display("tlb_hit_with_selectable_replacement regression: fail");
    end
    $finish;
  end

endmodule
